// File: hdl/cgcr_pkg.sv
// Shared types and constants for the circle vs. tile grid collision resolver.
// Holds item structs, sequencer states and the request/response of the div/sqrt unit.
// No dependencies.
package cgcr_pkg;

    // grid geometry
    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;
    localparam int MAP_DEPTH   = 1024;
    localparam int MAP_AW      = 10;
    localparam int IDX_W       = 16;  // row*W+col for grids up to 256x256

    // datapath widths
    localparam int CFG_W  = 24;
    localparam int POS_W  = 40;       // running position and box coordinates
    localparam int CC_W   = 36;       // nearest cell column / row
    localparam int OP_W   = 25;       // multiplier operand
    localparam int PROD_W = 50;
    localparam int NUM_W  = 50;       // div/sqrt dividend or radicand
    localparam int DEN_W  = 26;
    localparam int REM_W  = 28;
    localparam int CNT_W  = 6;
    localparam int SQRT_STEPS = NUM_W / 2;

    // item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_CELL_SIZE     = 2'd0;
    localparam logic [1:0] CFG_PLAYER_RADIUS = 2'd1;
    localparam logic [CFG_W-1:0] CELL_SIZE_RST = 24'd262144;
    localparam logic [CFG_W-1:0] RADIUS_RST    = 24'd65536;

    typedef struct packed {
        logic               operation;
        logic [9:0]         cell_index;
        logic               cell_wall;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic               collided;
        logic signed [31:0] resolved_x;
        logic signed [31:0] resolved_z;
    } t_out_item;

    // shared iterative unit
    typedef struct packed {
        logic             go;
        logic             root;   // 1: integer square root, 0: divide
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_unit_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } t_unit_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVX,
        S_DIVZ,
        S_RSQ,
        S_R2,
        S_ADDR,
        S_WALL,
        S_CHK,
        S_SQX,
        S_SQZ,
        S_CMP,
        S_ROOT,
        S_QSQX,
        S_QSQZ,
        S_QSUM,
        S_QSTART,
        S_QROOT,
        S_PMUL,
        S_PSTART,
        S_PWAIT,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

// File: hdl/circle_grid_collision_resolver_unit.sv
// A map write is taken with no result; writes can follow back to back.
// A query first runs two centre divisions, then visits the 5x5 cells around the centre; a
// wall cell that the circle overlaps takes a root and two divisions, with a second root
// when the first gives zero distance; the result follows the last cell.
// One item at a time; busy stays high for the whole query; results cannot be stalled.
// Reset: synchronous; the wall map is swept to open, one entry at a time, busy high.
module circle_grid_collision_resolver_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cgcr_pkg::t_in_item    i_item,
    output logic                  o_result_strobe,
    output cgcr_pkg::t_out_item   o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data
);

    localparam int PW = cgcr_pkg::POS_W;

    cgcr_pkg::t_state r_state, n_state;

    // configuration
    logic [cgcr_pkg::CFG_W-1:0] r_cell_size, r_radius, s_eff;

    // query datapath
    logic signed [PW-1:0]             r_x, r_z, r_pbx, r_pcol, r_prow;
    logic signed [PW-1:0]             r_dx, r_dz, r_qx, r_qz;
    logic signed [cgcr_pkg::CC_W-1:0] r_ccx, r_ccz;
    logic [cgcr_pkg::NUM_W-1:0]       r_num;
    logic                             r_neg, r_pneg, r_zero, r_selz, r_hit;
    logic                             r_inside, r_hi, r_rd;
    logic [2:0]                       r_cntc, r_cntr;
    logic [cgcr_pkg::PROD_W-1:0]      r_r2, r_acc;
    logic [cgcr_pkg::CFG_W-1:0]       r_fac;
    logic [cgcr_pkg::DEN_W-1:0]       r_den;
    logic signed [cgcr_pkg::PROD_W-1:0] r_prod;
    logic [cgcr_pkg::MAP_AW-1:0]      r_clr;
    logic                             r_strobe;
    cgcr_pkg::t_out_item              r_result;

    // wall map
    logic mem [cgcr_pkg::MAP_DEPTH];
    logic                        mem_we, mem_wd;
    logic [cgcr_pkg::MAP_AW-1:0] mem_wa, mem_ra;

    // shared unit
    cgcr_pkg::t_unit_req req;
    cgcr_pkg::t_unit_rsp rsp;

    // combinational helpers
    logic signed [cgcr_pkg::OP_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  cn_pos, cn_val, cn_mag;
    logic [PW-1:0]         cn_lane;
    logic [cgcr_pkg::NUM_W-1:0] cn_num;
    logic                  cn_sel_z;
    logic [cgcr_pkg::NUM_W-1:0] qs_u;
    logic signed [PW-1:0]  qs_s, pb_new;
    logic signed [cgcr_pkg::CC_W-1:0] cc_new;
    logic signed [cgcr_pkg::CC_W-1:0] col, row;
    logic                  in_grid;
    logic [cgcr_pkg::IDX_W-1:0] idx;
    logic signed [PW-1:0]  minx, maxx, minz, maxz, px, pz, cenx, cenz;
    logic signed [PW-1:0]  absdx, absdz, quo_s, delta, s_pos, r_pos;
    logic                  wall, query_go, write_go;
    logic [cgcr_pkg::NUM_W-1:0] pmag;

    assign s_eff       = (r_cell_size == '0) ? cgcr_pkg::CFG_W'(1) : r_cell_size;
    assign s_pos       = PW'(s_eff);
    assign r_pos       = PW'(r_radius);
    assign busy        = (r_state != cgcr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign query_go    = start && !busy && (i_item.operation == cgcr_pkg::OP_QUERY);
    assign write_go    = start && !busy && (i_item.operation == cgcr_pkg::OP_WRITE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= cgcr_pkg::CELL_SIZE_RST;
            r_radius    <= cgcr_pkg::RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cgcr_pkg::CFG_CELL_SIZE:     r_cell_size <= i_cfg_data;
                cgcr_pkg::CFG_PLAYER_RADIUS: r_radius    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // centre cell dividend: N = 2|2p + (L-1)s| + 2s, divided by 4s
    always_comb begin
        cn_sel_z = (r_state == cgcr_pkg::S_DIVX);
        cn_pos   = cn_sel_z ? r_z : PW'(i_item.pos_x);
        cn_lane  = cn_sel_z ? PW'(cgcr_pkg::GRID_HEIGHT - 1) * s_pos
                            : PW'(cgcr_pkg::GRID_WIDTH - 1) * s_pos;
        cn_val   = (cn_pos <<< 1) + $signed(cn_lane);
        cn_mag   = (cn_val < 0) ? -cn_val : cn_val;
        cn_num   = (cgcr_pkg::NUM_W'(cn_mag) << 1) + (cgcr_pkg::NUM_W'(s_eff) << 1);
    end

    // centre cell and box base from quotient: q*s = (N - rem) / 4
    always_comb begin
        qs_u   = (r_num - cgcr_pkg::NUM_W'(rsp.rem)) >> 2;
        qs_s   = r_neg ? -$signed(PW'(qs_u)) : $signed(PW'(qs_u));
        cc_new = r_neg ? -$signed(cgcr_pkg::CC_W'(rsp.quo))
                       : $signed(cgcr_pkg::CC_W'(rsp.quo));
        pb_new = (qs_s <<< 1) - (s_pos <<< 2)
               - ((r_state == cgcr_pkg::S_DIVZ) ? $signed(PW'(cgcr_pkg::GRID_HEIGHT) * s_pos)
                                                : $signed(PW'(cgcr_pkg::GRID_WIDTH) * s_pos));
    end

    // neighborhood cell address
    always_comb begin
        col     = r_ccx + $signed(cgcr_pkg::CC_W'(r_cntc)) - $signed(cgcr_pkg::CC_W'(2));
        row     = r_ccz + $signed(cgcr_pkg::CC_W'(r_cntr)) - $signed(cgcr_pkg::CC_W'(2));
        in_grid = (col >= 0) && (col < $signed(cgcr_pkg::CC_W'(cgcr_pkg::GRID_WIDTH)))
               && (row >= 0) && (row < $signed(cgcr_pkg::CC_W'(cgcr_pkg::GRID_HEIGHT)));
        idx     = cgcr_pkg::IDX_W'(row) * cgcr_pkg::IDX_W'(cgcr_pkg::GRID_WIDTH)
                + cgcr_pkg::IDX_W'(col);
        mem_ra  = idx[cgcr_pkg::MAP_AW-1:0];
    end

    // box clamp and cell centre offset
    always_comb begin
        minx  = r_pcol >>> 1;
        maxx  = minx + s_pos;
        minz  = r_prow >>> 1;
        maxz  = minz + s_pos;
        px    = (r_x < minx) ? minx : ((r_x > maxx) ? maxx : r_x);
        pz    = (r_z < minz) ? minz : ((r_z > maxz) ? maxz : r_z);
        cenx  = (r_pcol + s_pos) >>> 1;
        cenz  = (r_prow + s_pos) >>> 1;
        wall  = !r_inside || (!r_hi && r_rd);
        absdx = (r_dx < 0) ? -r_dx : r_dx;
        absdz = (r_dz < 0) ? -r_dz : r_dz;
        pmag  = (r_prod < 0) ? cgcr_pkg::NUM_W'(-r_prod) : cgcr_pkg::NUM_W'(r_prod);
        quo_s = $signed(PW'(rsp.quo));
        delta = r_pneg ? -quo_s : quo_s;
    end

    // wall map write port: clearing sweep or write item
    always_comb begin
        mem_we = (r_state == cgcr_pkg::S_CLEAR) || write_go;
        mem_wa = (r_state == cgcr_pkg::S_CLEAR) ? r_clr : i_item.cell_index;
        mem_wd = (r_state == cgcr_pkg::S_CLEAR) ? 1'b0 : i_item.cell_wall;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    // shared multiplier, registered
    always_comb begin
        mul_a = cgcr_pkg::OP_W'(r_dx);
        mul_b = cgcr_pkg::OP_W'(r_dx);
        unique case (r_state)
            cgcr_pkg::S_RSQ: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = $signed({1'b0, r_radius});
            end
            cgcr_pkg::S_SQX: begin
                mul_a = cgcr_pkg::OP_W'(r_dz);
                mul_b = cgcr_pkg::OP_W'(r_dz);
            end
            cgcr_pkg::S_QSQX: begin
                mul_a = cgcr_pkg::OP_W'(r_qx);
                mul_b = cgcr_pkg::OP_W'(r_qx);
            end
            cgcr_pkg::S_QSQZ: begin
                mul_a = cgcr_pkg::OP_W'(r_qz);
                mul_b = cgcr_pkg::OP_W'(r_qz);
            end
            cgcr_pkg::S_PMUL: begin
                mul_a = r_zero ? (r_selz ? cgcr_pkg::OP_W'(r_qz) : cgcr_pkg::OP_W'(r_qx))
                               : (r_selz ? cgcr_pkg::OP_W'(r_dz) : cgcr_pkg::OP_W'(r_dx));
                mul_b = $signed({1'b0, r_fac});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // unit requests
    always_comb begin
        req.go   = 1'b0;
        req.root = 1'b0;
        req.num  = cn_num;
        req.den  = cgcr_pkg::DEN_W'(s_eff) << 2;
        unique case (r_state)
            cgcr_pkg::S_IDLE: req.go = query_go;
            cgcr_pkg::S_DIVX: req.go = rsp.done;
            cgcr_pkg::S_CMP: begin
                req.go   = (r_acc < r_r2);
                req.root = 1'b1;
                req.num  = r_acc;
            end
            cgcr_pkg::S_QSTART: begin
                req.go   = 1'b1;
                req.root = 1'b1;
                req.num  = r_acc;
            end
            cgcr_pkg::S_PSTART: begin
                req.go  = 1'b1;
                req.num = pmag;
                req.den = r_den;
            end
            default: ;
        endcase
    end

    cgcr_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cgcr_pkg::S_CLEAR:
                if (r_clr == cgcr_pkg::MAP_AW'(cgcr_pkg::MAP_DEPTH - 1)) begin
                    n_state = cgcr_pkg::S_IDLE;
                end
            cgcr_pkg::S_IDLE:   if (query_go) n_state = cgcr_pkg::S_DIVX;
            cgcr_pkg::S_DIVX:   if (rsp.done) n_state = cgcr_pkg::S_DIVZ;
            cgcr_pkg::S_DIVZ:   if (rsp.done) n_state = cgcr_pkg::S_RSQ;
            cgcr_pkg::S_RSQ:    n_state = cgcr_pkg::S_R2;
            cgcr_pkg::S_R2:     n_state = cgcr_pkg::S_ADDR;
            cgcr_pkg::S_ADDR:   n_state = cgcr_pkg::S_WALL;
            cgcr_pkg::S_WALL:   n_state = wall ? cgcr_pkg::S_CHK : cgcr_pkg::S_NEXT;
            cgcr_pkg::S_CHK:
                if (absdx >= r_pos || absdz >= r_pos) begin
                    n_state = cgcr_pkg::S_NEXT;
                end else begin
                    n_state = cgcr_pkg::S_SQX;
                end
            cgcr_pkg::S_SQX:    n_state = cgcr_pkg::S_SQZ;
            cgcr_pkg::S_SQZ:    n_state = cgcr_pkg::S_CMP;
            cgcr_pkg::S_CMP:
                n_state = (r_acc >= r_r2) ? cgcr_pkg::S_NEXT : cgcr_pkg::S_ROOT;
            cgcr_pkg::S_ROOT:
                if (rsp.done) begin
                    n_state = (rsp.quo == '0) ? cgcr_pkg::S_QSQX : cgcr_pkg::S_PMUL;
                end
            cgcr_pkg::S_QSQX:   n_state = cgcr_pkg::S_QSQZ;
            cgcr_pkg::S_QSQZ:   n_state = cgcr_pkg::S_QSUM;
            cgcr_pkg::S_QSUM:   n_state = cgcr_pkg::S_QSTART;
            cgcr_pkg::S_QSTART: n_state = cgcr_pkg::S_QROOT;
            cgcr_pkg::S_QROOT:
                if (rsp.done) begin
                    n_state = (rsp.quo == '0) ? cgcr_pkg::S_NEXT : cgcr_pkg::S_PMUL;
                end
            cgcr_pkg::S_PMUL:   n_state = cgcr_pkg::S_PSTART;
            cgcr_pkg::S_PSTART: n_state = cgcr_pkg::S_PWAIT;
            cgcr_pkg::S_PWAIT:
                if (rsp.done) begin
                    n_state = r_selz ? cgcr_pkg::S_NEXT : cgcr_pkg::S_PMUL;
                end
            cgcr_pkg::S_NEXT:
                if (r_cntc == 3'd4 && r_cntr == 3'd4) begin
                    n_state = cgcr_pkg::S_DONE;
                end else begin
                    n_state = cgcr_pkg::S_ADDR;
                end
            cgcr_pkg::S_DONE:   n_state = cgcr_pkg::S_IDLE;
            default:            n_state = cgcr_pkg::S_IDLE;
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cgcr_pkg::S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == cgcr_pkg::S_DONE);
            if (r_state == cgcr_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // query datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cgcr_pkg::S_IDLE: begin
                r_x   <= PW'(i_item.pos_x);
                r_z   <= PW'(i_item.pos_z);
                r_num <= cn_num;
                r_neg <= (cn_val < 0);
            end
            cgcr_pkg::S_DIVX:
                if (rsp.done) begin
                    r_ccx <= cc_new;
                    r_pbx <= pb_new;
                    r_num <= cn_num;
                    r_neg <= (cn_val < 0);
                end
            cgcr_pkg::S_DIVZ:
                if (rsp.done) begin
                    r_ccz  <= cc_new;
                    r_prow <= pb_new;
                end
            cgcr_pkg::S_R2: begin
                r_r2   <= cgcr_pkg::PROD_W'(r_prod);
                r_pcol <= r_pbx;
                r_cntc <= '0;
                r_cntr <= '0;
                r_hit  <= 1'b0;
            end
            cgcr_pkg::S_ADDR: begin
                r_inside <= in_grid;
                r_hi     <= (idx >= cgcr_pkg::IDX_W'(cgcr_pkg::MAP_DEPTH));
            end
            cgcr_pkg::S_WALL: begin
                r_dx <= r_x - px;
                r_dz <= r_z - pz;
                r_qx <= r_x - cenx;
                r_qz <= r_z - cenz;
            end
            cgcr_pkg::S_SQX:  r_acc <= cgcr_pkg::PROD_W'(r_prod);
            cgcr_pkg::S_SQZ:  r_acc <= r_acc + cgcr_pkg::PROD_W'(r_prod);
            cgcr_pkg::S_CMP:  if (r_acc < r_r2) r_hit <= 1'b1;
            cgcr_pkg::S_ROOT:
                if (rsp.done) begin
                    r_fac  <= r_radius - cgcr_pkg::CFG_W'(rsp.quo);
                    r_den  <= cgcr_pkg::DEN_W'(rsp.quo);
                    r_zero <= 1'b0;
                    r_selz <= 1'b0;
                end
            cgcr_pkg::S_QSQZ: r_acc <= cgcr_pkg::PROD_W'(r_prod);
            cgcr_pkg::S_QSUM: r_acc <= r_acc + cgcr_pkg::PROD_W'(r_prod);
            cgcr_pkg::S_QROOT:
                if (rsp.done) begin
                    if (rsp.quo == '0) begin
                        r_x <= r_x + r_pos;
                    end
                    r_fac  <= r_radius;
                    r_den  <= cgcr_pkg::DEN_W'(rsp.quo);
                    r_zero <= 1'b1;
                    r_selz <= 1'b0;
                end
            cgcr_pkg::S_PSTART: r_pneg <= (r_prod < 0);
            cgcr_pkg::S_PWAIT:
                if (rsp.done) begin
                    if (r_selz) begin
                        r_z <= r_z + delta;
                    end else begin
                        r_x    <= r_x + delta;
                        r_selz <= 1'b1;
                    end
                end
            cgcr_pkg::S_NEXT:
                if (r_cntc == 3'd4) begin
                    r_cntc <= '0;
                    r_pcol <= r_pbx;
                    r_cntr <= r_cntr + 1'b1;
                    r_prow <= r_prow + (s_pos <<< 1);
                end else begin
                    r_cntc <= r_cntc + 1'b1;
                    r_pcol <= r_pcol + (s_pos <<< 1);
                end
            cgcr_pkg::S_DONE: begin
                r_result.collided <= r_hit;
                r_result.resolved_x <=
                    (r_x > $signed(PW'(32'sh7FFFFFFF))) ? 32'sh7FFFFFFF :
                    ((r_x < -$signed(PW'(33'h080000000))) ? 32'sh80000000 : r_x[31:0]);
                r_result.resolved_z <=
                    (r_z > $signed(PW'(32'sh7FFFFFFF))) ? 32'sh7FFFFFFF :
                    ((r_z < -$signed(PW'(33'h080000000))) ? 32'sh80000000 : r_z[31:0]);
            end
            default: ;
        endcase
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

`ifndef NO_ASSERTIONS
    // a result beat follows only the final sequencer step
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == cgcr_pkg::S_DONE))
        else $error("result beat without a finished query");

    // one beat per query
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result beat repeated");

    // the div/sqrt unit only finishes while the sequencer waits for it
    a_unit_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> (r_state == cgcr_pkg::S_DIVX || r_state == cgcr_pkg::S_DIVZ ||
                      r_state == cgcr_pkg::S_ROOT || r_state == cgcr_pkg::S_QROOT ||
                      r_state == cgcr_pkg::S_PWAIT))
        else $error("div/sqrt result dropped");
`endif

endmodule

// File: hdl/cgcr_divsqrt.sv
// Shared iterative unit: restoring unsigned division (one quotient bit a cycle)
// or truncating integer square root (one root bit a cycle).
// Depends on cgcr_pkg.
module cgcr_divsqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cgcr_pkg::t_unit_req   i_req,
    output cgcr_pkg::t_unit_rsp   o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic                          r_root, n_root;
    logic [cgcr_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [cgcr_pkg::NUM_W-1:0]    r_num, n_num;
    logic [cgcr_pkg::DEN_W-1:0]    r_den, n_den;
    logic [cgcr_pkg::NUM_W-1:0]    r_quo, n_quo;
    logic [cgcr_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [cgcr_pkg::REM_W-1:0]    t_div, t_sq, trial;
    logic                          last;

    // one step of divide or root
    always_comb begin
        t_div  = {r_rem[cgcr_pkg::REM_W-2:0], r_num[cgcr_pkg::NUM_W-1]};
        t_sq   = {r_rem[cgcr_pkg::REM_W-3:0], r_num[cgcr_pkg::NUM_W-1 -: 2]};
        trial  = {r_quo[cgcr_pkg::REM_W-3:0], 2'b01};
        last   = 1'b0;
        n_busy = r_busy;
        n_done = 1'b0;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_req.go) begin
            n_busy = 1'b1;
            n_root = i_req.root;
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_quo  = '0;
            n_rem  = '0;
            n_cnt  = '0;
        end else if (r_busy) begin
            if (r_root) begin
                if (t_sq >= trial) begin
                    n_rem = t_sq - trial;
                    n_quo = {r_quo[cgcr_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = t_sq;
                    n_quo = {r_quo[cgcr_pkg::NUM_W-2:0], 1'b0};
                end
                n_num = {r_num[cgcr_pkg::NUM_W-3:0], 2'b00};
                last  = (r_cnt == cgcr_pkg::CNT_W'(cgcr_pkg::SQRT_STEPS - 1));
            end else begin
                if (t_div >= {2'b00, r_den}) begin
                    n_rem = t_div - {2'b00, r_den};
                    n_quo = {r_quo[cgcr_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = t_div;
                    n_quo = {r_quo[cgcr_pkg::NUM_W-2:0], 1'b0};
                end
                n_num = {r_num[cgcr_pkg::NUM_W-2:0], 1'b0};
                last  = (r_cnt == cgcr_pkg::CNT_W'(cgcr_pkg::NUM_W - 1));
            end
            n_cnt = r_cnt + 1'b1;
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_root <= n_root;
        r_cnt  <= n_cnt;
        r_num  <= n_num;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
